[rtl/rk4s_pkg.sv]
package rk4s_pkg;

    localparam int unsigned CoordWidth = 32;
    localparam int unsigned LenWidth   = 16;

    typedef enum logic [2:0] {
        REG_START_X     = 3'd0,
        REG_START_Y     = 3'd1,
        REG_START_Z     = 3'd2,
        REG_STEP_LENGTH = 3'd3,
        REG_STEP_COUNT  = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_POINT    = 2'd0,
        KIND_QUERY    = 2'd1,
        KIND_FINISHED = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_MUL,
        ST_DIV,
        ST_KUPD,
        ST_D6,
        ST_FIN
    } state_t;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [31:0] sat33(input logic [32:0] s);
        if (s[32] != s[31])
        begin
            return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return s[31:0];
    endfunction

endpackage

[rtl/rk4_streamline_stepper.sv]
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  mode, sample_valid, field_x, field_y, field_z
// out      output     out_valid / out_stall kind, point_x, point_y, point_z, last
// cfg      input      wr_en                wr_index, wr_data
//
// A start item, or an invalid sample while a streamline is active, is answered in the
// following cycle. A valid sample runs three shift-add squares, a bit-pair square
// root, then per component a shift-add product and a restoring divide, and a last
// state to add the slopes. The fourth sample of a step adds three divides by six and
// a finishing state. Reset (rst_n, asynchronous) leaves the block idle with the
// register defaults loaded.
// Input is taken only while no item is in work and the output register is empty.
module rk4_streamline_stepper
    import rk4s_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic        sample_valid,
    input  logic [31:0] field_x,
    input  logic [31:0] field_y,
    input  logic [31:0] field_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [31:0] point_x,
    output logic [31:0] point_y,
    output logic [31:0] point_z,
    output logic        last,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [31:0] wr_data
);

    state_t state_reg, state_next;

    logic [31:0] start_reg [3];
    logic [15:0] step_len_reg, step_cnt_reg;

    logic [31:0] base_reg [3], base_next [3];
    logic [19:0] sum_reg [3], sum_next [3];
    logic [17:0] k_reg [3], k_next [3];
    logic [31:0] f_reg [3], f_next [3];
    logic [1:0]  stage_reg, stage_next;
    logic [15:0] steps_reg, steps_next;
    logic        active_reg, active_next;

    logic [1:0]  comp_reg, comp_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] mcand_reg, mcand_next;
    logic [31:0] mplier_reg, mplier_next;
    logic [63:0] sqx_reg, sqx_next;
    logic [63:0] sqres_reg, sqres_next;
    logic [63:0] sqbit_reg, sqbit_next;
    logic [31:0] den_reg, den_next;
    logic [32:0] rem_reg, rem_next;
    logic [47:0] dsh_reg, dsh_next;
    logic [18:0] quo_reg, quo_next;
    logic        neg_reg, neg_next;

    logic        ov_reg, ov_next, pv_reg, pv_next;
    logic [1:0]  okind_reg, okind_next, pkind_reg, pkind_next;
    logic        olast_reg, olast_next, plast_reg, plast_next;
    logic [31:0] opt_reg [3], opt_next [3], ppt_reg [3], ppt_next [3];

    logic        accept;

    assign in_stall  = !((state_reg == ST_IDLE) && !ov_reg);
    assign accept    = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign kind      = okind_reg;
    assign point_x   = opt_reg[0];
    assign point_y   = opt_reg[1];
    assign point_z   = opt_reg[2];
    assign last      = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            start_reg    <= '{default: '0};
            step_len_reg <= 16'd2621;
            step_cnt_reg <= 16'd1250;
            base_reg     <= '{default: '0};
            sum_reg      <= '{default: '0};
            stage_reg    <= '0;
            steps_reg    <= '0;
            active_reg   <= 1'b0;
            comp_reg     <= '0;
            cnt_reg      <= '0;
            ov_reg       <= 1'b0;
            pv_reg       <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            base_reg   <= base_next;
            sum_reg    <= sum_next;
            stage_reg  <= stage_next;
            steps_reg  <= steps_next;
            active_reg <= active_next;
            comp_reg   <= comp_next;
            cnt_reg    <= cnt_next;
            ov_reg     <= ov_next;
            pv_reg     <= pv_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_START_X:     start_reg[0] <= wr_data;
                    REG_START_Y:     start_reg[1] <= wr_data;
                    REG_START_Z:     start_reg[2] <= wr_data;
                    REG_STEP_LENGTH: step_len_reg <= wr_data[15:0];
                    REG_STEP_COUNT:  step_cnt_reg <= wr_data[15:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        f_reg      <= f_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        sqx_reg    <= sqx_next;
        sqres_reg  <= sqres_next;
        sqbit_reg  <= sqbit_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        quo_reg    <= quo_next;
        neg_reg    <= neg_next;
        okind_reg  <= okind_next;
        pkind_reg  <= pkind_next;
        olast_reg  <= olast_next;
        plast_reg  <= plast_next;
        opt_reg    <= opt_next;
        ppt_reg    <= ppt_next;
    end

    function automatic logic [31:0] pick_f(input logic [31:0] f [3], input logic [1:0] c);
        unique case (c)
            2'd0:    return f[0];
            2'd1:    return f[1];
            default: return f[2];
        endcase
    endfunction

    function automatic logic [19:0] pick_s(input logic [19:0] s [3], input logic [1:0] c);
        unique case (c)
            2'd0:    return s[0];
            2'd1:    return s[1];
            default: return s[2];
        endcase
    endfunction

    always_comb
    begin
        logic [32:0] rs;
        logic        qbit;
        logic [63:0] sqt;
        logic [31:0] fsel;
        logic [47:0] num;
        logic [17:0] kv;
        logic [17:0] kh;
        logic [19:0] sv;
        logic [18:0] sabs;
        logic [19:0] q6;
        logic [1:0]  cn;

        state_next  = state_reg;
        base_next   = base_reg;
        sum_next    = sum_reg;
        k_next      = k_reg;
        f_next      = f_reg;
        stage_next  = stage_reg;
        steps_next  = steps_reg;
        active_next = active_reg;
        comp_next   = comp_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        sqx_next    = sqx_reg;
        sqres_next  = sqres_reg;
        sqbit_next  = sqbit_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        dsh_next    = dsh_reg;
        quo_next    = quo_reg;
        neg_next    = neg_reg;
        ov_next     = ov_reg;
        pv_next     = pv_reg;
        okind_next  = okind_reg;
        pkind_next  = pkind_reg;
        olast_next  = olast_reg;
        plast_next  = plast_reg;
        opt_next    = opt_reg;
        ppt_next    = ppt_reg;

        rs   = {rem_reg[31:0], dsh_reg[47]};
        qbit = (rs >= {1'b0, den_reg});
        sqt  = sqres_reg + sqbit_reg;
        cn   = comp_reg + 2'd1;
        fsel = '0;
        num  = '0;
        kv   = '0;
        kh   = '0;
        sv   = '0;
        sabs = '0;
        q6   = '0;

        // Output register drains first; a second result waits in the pending slot.
        if (ov_reg && !out_stall)
        begin
            if (pv_reg)
            begin
                okind_next = pkind_reg;
                olast_next = plast_reg;
                opt_next   = ppt_reg;
                pv_next    = 1'b0;
            end
            else
            begin
                ov_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!mode)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            base_next[i] = start_reg[i];
                            sum_next[i]  = '0;
                            opt_next[i]  = start_reg[i];
                            ppt_next[i]  = start_reg[i];
                        end
                        stage_next = '0;
                        steps_next = '0;
                        ov_next    = 1'b1;
                        if (step_cnt_reg == '0)
                        begin
                            active_next = 1'b0;
                            okind_next  = KIND_FINISHED;
                            olast_next  = 1'b1;
                        end
                        else
                        begin
                            active_next = 1'b1;
                            okind_next  = KIND_POINT;
                            olast_next  = 1'b0;
                            pv_next     = 1'b1;
                            pkind_next  = KIND_QUERY;
                            plast_next  = 1'b1;
                        end
                    end
                    else if (active_reg)
                    begin
                        if (!sample_valid)
                        begin
                            active_next = 1'b0;
                            stage_next  = '0;
                            ov_next     = 1'b1;
                            okind_next  = KIND_FINISHED;
                            olast_next  = 1'b1;
                            opt_next    = base_reg;
                        end
                        else
                        begin
                            f_next[0]   = field_x;
                            f_next[1]   = field_y;
                            f_next[2]   = field_z;
                            acc_next    = '0;
                            mcand_next  = {32'd0, abs32(field_x)};
                            mplier_next = abs32(field_x);
                            comp_next   = '0;
                            cnt_next    = '0;
                            state_next  = ST_SQ;
                        end
                    end
                end
            end

            ST_SQ, ST_MUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 5'd1;
                if (state_reg == ST_SQ && cnt_reg == 5'd31)
                begin
                    cnt_next = '0;
                    if (comp_reg == 2'd2)
                    begin
                        sqx_next   = acc_next;
                        sqres_next = '0;
                        sqbit_next = 64'd1 << 62;
                        state_next = ST_SQRT;
                    end
                    else
                    begin
                        fsel        = pick_f(f_reg, cn);
                        comp_next   = cn;
                        mcand_next  = {32'd0, abs32(fsel)};
                        mplier_next = abs32(fsel);
                    end
                end
                else if (state_reg == ST_MUL && cnt_reg == 5'd15)
                begin
                    num        = acc_next[47:0];
                    rem_next   = {2'b00, num[47:17]};
                    dsh_next   = {num[16:0], 31'd0};
                    quo_next   = '0;
                    neg_next   = pick_f(f_reg, comp_reg) >> 31 != 32'd0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end

            ST_SQRT:
            begin
                if (sqx_reg >= sqt)
                begin
                    sqx_next   = sqx_reg - sqt;
                    sqres_next = (sqres_reg >> 1) + sqbit_reg;
                end
                else
                begin
                    sqres_next = sqres_reg >> 1;
                end
                sqbit_next = sqbit_reg >> 2;
                cnt_next   = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    den_next    = (sqres_next[31:0] == '0) ? 32'd1 : sqres_next[31:0];
                    comp_next   = '0;
                    cnt_next    = '0;
                    acc_next    = '0;
                    mcand_next  = {32'd0, abs32(f_reg[0])};
                    mplier_next = {16'd0, step_len_reg};
                    state_next  = ST_MUL;
                end
            end

            ST_DIV, ST_D6:
            begin
                rem_next = qbit ? (rs - {1'b0, den_reg}) : rs;
                quo_next = {quo_reg[17:0], qbit};
                dsh_next = dsh_reg << 1;
                cnt_next = cnt_reg + 5'd1;
                if (state_reg == ST_DIV && cnt_reg == 5'd16)
                begin
                    kv = {1'b0, quo_next[16:0]};
                    k_next[comp_reg] = neg_reg ? (~kv + 18'd1) : kv;
                    cnt_next = '0;
                    if (comp_reg == 2'd2)
                    begin
                        state_next = ST_KUPD;
                    end
                    else
                    begin
                        comp_next   = cn;
                        acc_next    = '0;
                        mcand_next  = {32'd0, abs32(pick_f(f_reg, cn))};
                        mplier_next = {16'd0, step_len_reg};
                        state_next  = ST_MUL;
                    end
                end
                else if (state_reg == ST_D6 && cnt_reg == 5'd18)
                begin
                    q6 = {1'b0, quo_next};
                    q6 = neg_reg ? (~q6 + 20'd1) : q6;
                    base_next[comp_reg] = sat33({base_reg[comp_reg][31], base_reg[comp_reg]}
                                                + {{13{q6[19]}}, q6});
                    sum_next[comp_reg] = '0;
                    cnt_next = '0;
                    if (comp_reg == 2'd2)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        sv         = pick_s(sum_reg, cn);
                        sabs       = sv[19] ? (~sv[18:0] + 19'd1) : sv[18:0];
                        comp_next  = cn;
                        neg_next   = sv[19];
                        rem_next   = '0;
                        dsh_next   = {sabs, 29'd0};
                        quo_next   = '0;
                    end
                end
            end

            ST_KUPD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (stage_reg == 2'd0 || stage_reg == 2'd3)
                    begin
                        sum_next[i] = sum_reg[i] + {{2{k_reg[i][17]}}, k_reg[i]};
                    end
                    else
                    begin
                        sum_next[i] = sum_reg[i] + {k_reg[i][17], k_reg[i], 1'b0};
                    end
                end
                if (stage_reg == 2'd3)
                begin
                    sv         = sum_next[0];
                    sabs       = sv[19] ? (~sv[18:0] + 19'd1) : sv[18:0];
                    comp_next  = '0;
                    neg_next   = sv[19];
                    rem_next   = '0;
                    dsh_next   = {sabs, 29'd0};
                    quo_next   = '0;
                    den_next   = 32'd6;
                    cnt_next   = '0;
                    state_next = ST_D6;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        // Halving truncates toward zero, so a negative k is rounded up first.
                        kh = (stage_reg == 2'd2) ? k_reg[i]
                           : 18'($signed(k_reg[i] + {17'd0, k_reg[i][17]}) >>> 1);
                        opt_next[i] = sat33({base_reg[i][31], base_reg[i]}
                                            + {{15{kh[17]}}, kh});
                    end
                    stage_next = stage_reg + 2'd1;
                    ov_next    = 1'b1;
                    okind_next = KIND_QUERY;
                    olast_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_FIN:
            begin
                steps_next = steps_reg + 16'd1;
                stage_next = '0;
                opt_next   = base_reg;
                ppt_next   = base_reg;
                ov_next    = 1'b1;
                if (steps_next >= step_cnt_reg)
                begin
                    active_next = 1'b0;
                    okind_next  = KIND_FINISHED;
                    olast_next  = 1'b1;
                end
                else
                begin
                    okind_next = KIND_POINT;
                    olast_next = 1'b0;
                    pv_next    = 1'b1;
                    pkind_next = KIND_QUERY;
                    plast_next = 1'b1;
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
